FILE: rtl/core/hft_pkg.sv
// Shared types and constants for the head tracker frame parser.
// No dependencies; every other file in rtl/core but hft_channels refers to this package.
package hft_pkg;

   // Item codes
   localparam logic OpPoll = 1'b0;
   localparam logic OpByte = 1'b1;

   // Result status codes
   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusChecksum = 2'd1;
   localparam logic [1:0] StatusHeader   = 2'd2;

   // Frame layout
   localparam logic [7:0] HdrMark      = 8'hFF;
   localparam int         PosW         = 3;
   localparam logic [PosW-1:0] HdrLastPos   = 3'd7;
   localparam logic [PosW-1:0] PlainLastPos = 3'd6;

   // Configuration port
   localparam int          CsrAddrW     = 3;
   localparam int          CsrDataW     = 32;
   localparam logic        RegPlainMode = 1'b0;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      logic [1:0]         status;
   } result_type;

endpackage

FILE: rtl/core/hft_channels.sv
// Valid/ready channel interfaces for the head tracker frame parser.
// Depends on nothing but plain logic types.
interface hft_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface hft_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] yaw_out;
   logic signed [15:0] pitch_out;
   logic signed [15:0] roll_out;
   logic [1:0]         frame_status;

   modport source (output valid, output yaw_out, output pitch_out, output roll_out,
                   output frame_status, input ready);
   modport sink (input valid, input yaw_out, input pitch_out, input roll_out,
                 input frame_status, output ready);
endinterface

FILE: rtl/core/hft_csr.sv
// APB-style register file holding the plain_mode register.
// Depends on hft_pkg.
module hft_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [hft_pkg::CsrAddrW-1:0] paddr,
   input  logic [hft_pkg::CsrDataW-1:0] pwdata,
   output logic [hft_pkg::CsrDataW-1:0] prdata,
   output logic                       pready,
   output logic                       plain_mode
);

   logic plain_mode_ff;
   logic plain_mode_in;
   logic sel_plain;

   assign pready    = 1'b1;
   assign sel_plain = (paddr[hft_pkg::CsrAddrW-1:2] == hft_pkg::RegPlainMode);

   always_comb begin
      plain_mode_in = plain_mode_ff;
      if (psel && penable && pwrite && sel_plain) begin
         plain_mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plain_mode_ff <= 1'b0;
      end else begin
         plain_mode_ff <= plain_mode_in;
      end
   end

   assign prdata     = sel_plain ? {{(hft_pkg::CsrDataW-1){1'b0}}, plain_mode_ff}
                                 : '0;
   assign plain_mode = plain_mode_ff;

endmodule

FILE: rtl/core/hft_in_stage.sv
// Input register of the frame parser: captures one item per transfer.
// Depends on hft_pkg.
module hft_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hft_pkg::item_type req_item,
   input  logic              take,
   output logic              item_valid,
   output hft_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   hft_pkg::item_type item_ff;
   logic              load;

   // accept when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/core/hft_parse.sv
// Frame state, checksum and angle assembly, plus the result register.
// Depends on hft_pkg.
module hft_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                plain_mode,
   input  logic                item_valid,
   input  hft_pkg::item_type   item,
   output logic                take,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hft_pkg::result_type rsp_data
);

   logic [hft_pkg::PosW-1:0] pos_ff, pos_in;
   logic                     dead_ff, dead_in;
   logic [7:0]               sum_ff, sum_in;
   logic [15:0]              part_yaw_ff, part_yaw_in;
   logic [15:0]              part_pitch_ff, part_pitch_in;
   logic [15:0]              part_roll_ff, part_roll_in;
   logic [15:0]              held_yaw_ff, held_yaw_in;
   logic [15:0]              held_pitch_ff, held_pitch_in;
   logic [15:0]              held_roll_ff, held_roll_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   hft_pkg::result_type      rsp_data_ff;

   logic [hft_pkg::PosW-1:0] last_pos;
   logic [hft_pkg::PosW-1:0] angle_idx;
   logic [7:0]               sum_next;
   logic                     emit;
   logic [1:0]               status;

   assign take      = item_valid && (!rsp_valid_ff || rsp_ready);
   assign last_pos  = plain_mode ? hft_pkg::PlainLastPos : hft_pkg::HdrLastPos;
   assign angle_idx = plain_mode ? pos_ff : pos_ff - 3'd1;
   assign sum_next  = sum_ff + item.rx_byte;

   always_comb begin
      pos_in        = pos_ff;
      dead_in       = dead_ff;
      sum_in        = sum_ff;
      part_yaw_in   = part_yaw_ff;
      part_pitch_in = part_pitch_ff;
      part_roll_in  = part_roll_ff;
      held_yaw_in   = held_yaw_ff;
      held_pitch_in = held_pitch_ff;
      held_roll_in  = held_roll_ff;
      emit          = 1'b0;
      status        = hft_pkg::StatusOk;
      if (take) begin
         if (item.op == hft_pkg::OpPoll) begin
            pos_in        = '0;
            sum_in        = '0;
            part_yaw_in   = '0;
            part_pitch_in = '0;
            part_roll_in  = '0;
            dead_in       = 1'b0;
         end else if (!dead_ff) begin
            if (pos_ff >= last_pos) begin
               // closing byte: checksum, unchecked in plain mode
               dead_in = 1'b1;
               emit    = 1'b1;
               if (plain_mode || (item.rx_byte == sum_ff)) begin
                  held_yaw_in   = part_yaw_ff;
                  held_pitch_in = part_pitch_ff;
                  held_roll_in  = part_roll_ff;
               end else begin
                  status = hft_pkg::StatusChecksum;
               end
            end else if (!plain_mode && (pos_ff == '0)) begin
               if (item.rx_byte != hft_pkg::HdrMark) begin
                  dead_in = 1'b1;
                  emit    = 1'b1;
                  status  = hft_pkg::StatusHeader;
               end else begin
                  sum_in = sum_next;
                  pos_in = pos_ff + 3'd1;
               end
            end else begin
               case (angle_idx[2:1])
                  2'd0: begin
                     if (angle_idx[0]) part_yaw_in[7:0] = item.rx_byte;
                     else part_yaw_in[15:8] = item.rx_byte;
                  end
                  2'd1: begin
                     if (angle_idx[0]) part_pitch_in[7:0] = item.rx_byte;
                     else part_pitch_in[15:8] = item.rx_byte;
                  end
                  default: begin
                     if (angle_idx[0]) part_roll_in[7:0] = item.rx_byte;
                     else part_roll_in[15:8] = item.rx_byte;
                  end
               endcase
               sum_in = sum_next;
               pos_in = pos_ff + 3'd1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         dead_ff       <= 1'b1;
         sum_ff        <= '0;
         part_yaw_ff   <= '0;
         part_pitch_ff <= '0;
         part_roll_ff  <= '0;
         held_yaw_ff   <= '0;
         held_pitch_ff <= '0;
         held_roll_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         dead_ff       <= dead_in;
         sum_ff        <= sum_in;
         part_yaw_ff   <= part_yaw_in;
         part_pitch_ff <= part_pitch_in;
         part_roll_ff  <= part_roll_in;
         held_yaw_ff   <= held_yaw_in;
         held_pitch_ff <= held_pitch_in;
         held_roll_ff  <= held_roll_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff.yaw    <= held_yaw_in;
         rsp_data_ff.pitch  <= held_pitch_in;
         rsp_data_ff.roll   <= held_roll_in;
         rsp_data_ff.status <= status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_poll_restarts: assert property (@(posedge clock) disable iff (reset)
      take && (item.op == hft_pkg::OpPoll) |=> !dead_ff && (pos_ff == '0) && (sum_ff == '0))
      else $error("poll did not restart the frame");

   a_result_ends_frame: assert property (@(posedge clock) disable iff (reset)
      emit |=> dead_ff && rsp_valid_ff)
      else $error("result without frame end");

   a_result_matches_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.yaw == held_yaw_ff) && (rsp_data_ff.pitch == held_pitch_ff)
                       && (rsp_data_ff.roll == held_roll_ff))
      else $error("pending result disagrees with held angles");

   a_no_emit_when_dead: assert property (@(posedge clock) disable iff (reset)
      take && dead_ff && (item.op == hft_pkg::OpByte) |-> !emit)
      else $error("result from a dead frame");
`endif

endmodule

FILE: rtl/core/head_tracker_frame_parser_unit.sv
// Top level of the head tracker frame parser: channels, register port, core.
// Depends on hft_pkg, hft_channels, hft_csr, hft_in_stage and hft_parse.
//
//   channel   direction  payload                                       handshake
//   req_if    in         op, rx_byte                                   valid/ready
//   rsp_if    out        yaw_out, pitch_out, roll_out, frame_status    valid/ready
//   csr       in/out     plain_mode at byte address 0 (APB-style)      psel/penable
//
// One byte or poll is accepted per cycle while no result is stalled; each item
// is resolved in the input register, and its result (if any) is written to the
// output register as the item leaves it, then offered on rsp_if. A stalled
// result holds the input register, and so req_if once that register is full,
// until taken. Reset is synchronous and leaves the parser waiting for a poll.
module head_tracker_frame_parser_unit (
   input  logic                         clock,
   input  logic                         reset,
   hft_req_if.sink                      req_if,
   hft_rsp_if.source                    rsp_if,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [hft_pkg::CsrAddrW-1:0] paddr,
   input  logic [hft_pkg::CsrDataW-1:0] pwdata,
   output logic [hft_pkg::CsrDataW-1:0] prdata,
   output logic                         pready
);

   logic                plain_mode;
   logic                take;
   logic                item_valid;
   hft_pkg::item_type   req_item;
   hft_pkg::item_type   item;
   hft_pkg::result_type rsp_data;
   logic                req_ready;
   logic                rsp_valid;

   assign req_item.op      = req_if.op;
   assign req_item.rx_byte = req_if.rx_byte;
   assign req_if.ready     = req_ready;

   hft_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .plain_mode (plain_mode)
   );

   hft_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   hft_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .plain_mode (plain_mode),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_if.valid        = rsp_valid;
   assign rsp_if.yaw_out      = rsp_data.yaw;
   assign rsp_if.pitch_out    = rsp_data.pitch;
   assign rsp_if.roll_out     = rsp_data.roll;
   assign rsp_if.frame_status = rsp_data.status;

endmodule
